>>> hdl/tt4_pkg.sv
// Shared types, protocol constants and the capability container table.
`timescale 1ns / 1ps

package tt4_pkg;

    localparam int CC_BYTES = 15;
    localparam int HW_W     = 14;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [7:0] INS_SELECT = 8'hA4;
    localparam logic [7:0] INS_READ   = 8'hB0;
    localparam logic [7:0] INS_WRITE  = 8'hD6;

    localparam logic [7:0] P1_BY_AID  = 8'h04;
    localparam logic [7:0] P1_BY_FILE = 8'h00;

    localparam logic [15:0] FID_CC   = 16'hE103;
    localparam logic [15:0] FID_NDEF = 16'hE104;

    localparam logic [7:0] SW1_OK  = 8'h90;
    localparam logic [7:0] SW2_OK  = 8'h00;
    localparam logic [7:0] SW1_ERR = 8'h6A;
    localparam logic [7:0] SW2_ERR = 8'h82;

    localparam logic [8:0] POS_MAX = 9'd511;

    typedef enum logic [1:0] {
        FILE_NONE = 2'd0,
        FILE_CC   = 2'd1,
        FILE_NDEF = 2'd2
    } file_sel_t;

    typedef enum logic [2:0] {
        RSP_NONE    = 3'd0,
        RSP_OK      = 3'd1,
        RSP_ERR     = 3'd2,
        RSP_RD_CC   = 3'd3,
        RSP_RD_NDEF = 3'd4
    } rsp_kind_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] request_byte;
        logic       request_last;
    } req_item_t;

    // Result of one pull, before the store read data is merged in.
    typedef struct packed {
        logic            resp_valid;
        logic            use_mem;
        logic [7:0]      direct_byte;
        logic            last;
        logic [HW_W-1:0] high_water;
    } rsp_meta_t;

    function automatic logic [7:0] cc_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h0F;
            4'd2:    b = 8'h20;
            4'd3:    b = 8'h00;
            4'd4:    b = 8'hF6;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'hF6;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h06;
            4'd9:    b = 8'hE1;
            4'd10:   b = 8'h04;
            4'd11:   b = 8'hFF;
            4'd12:   b = 8'hFF;
            4'd13:   b = 8'h00;
            4'd14:   b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/tt4_channels.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface tt4_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] request_byte;
    logic       request_last;

    modport source (output valid, output operation, output request_byte,
                    output request_last, input ready);
    modport sink   (input valid, input operation, input request_byte,
                    input request_last, output ready);
endinterface

interface tt4_rsp_if;
    logic        valid;
    logic        ready;
    logic        response_valid;
    logic [7:0]  response_byte;
    logic        response_last;
    logic [13:0] ndef_high_water;

    modport source (output valid, output response_valid, output response_byte,
                    output response_last, output ndef_high_water, input ready);
    modport sink   (input valid, input response_valid, input response_byte,
                    input response_last, input ndef_high_water, output ready);
endinterface

>>> hdl/tt4_ndef_ram.sv
// NDEF byte store: single port, registered read.
`timescale 1ns / 1ps

module tt4_ndef_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tt4_ctrl.sv
// Frame parser, response sequencer and store address generation.
`timescale 1ns / 1ps

module tt4_ctrl
    import tt4_pkg::*;
#(
    parameter int NDEF_STORE_BYTES = 8192,
    parameter int AW               = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  req_item_t     item,
    output rsp_meta_t     meta,
    output logic          ram_wr_en,
    output logic          ram_rd_en,
    output logic [AW-1:0] ram_addr,
    output logic [7:0]    ram_wr_data
);

    localparam int          LEN_W     = $clog2(NDEF_STORE_BYTES + 1);
    localparam logic [16:0] STORE_END = 17'(NDEF_STORE_BYTES);

    logic [8:0]       pos_reg,   pos_next;
    logic [7:0]       pcb_reg,   pcb_next;
    logic [7:0]       ins_reg,   ins_next;
    logic [7:0]       p1_reg,    p1_next;
    logic [15:0]      fo_reg,    fo_next;
    logic [7:0]       tl_reg,    tl_next;
    logic [15:0]      fid_reg,   fid_next;
    file_sel_t        sel_reg,   sel_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    rsp_kind_t        kind_reg,  kind_next;
    logic [8:0]       rpos_reg,  rpos_next;

    logic                  is_push;
    logic                  is_pull;
    logic [9:0]            frame_len;
    logic [8:0]            idx;
    logic [16:0]           wr_addr;
    logic [16:0]           wr_addr_inc;
    logic                  write_ok_cur;
    logic                  write_ok_new;
    logic                  wr_hit;
    logic [8:0]            dlen;
    logic [16:0]           rd_addr;
    logic [LEN_W+HW_W-1:0] len_wide;

    assign is_push = in_fire && (item.operation == OP_PUSH);
    assign is_pull = in_fire && (item.operation == OP_PULL);

    assign idx          = pos_reg - 9'd6;
    assign wr_addr      = {1'b0, fo_reg} + {8'b0, idx};
    assign wr_addr_inc  = wr_addr + 17'd1;
    assign write_ok_cur = (sel_reg == FILE_NDEF) &&
                          (({1'b0, fo_reg} + {9'b0, tl_reg}) <= STORE_END);
    assign wr_hit = is_push && (pos_reg >= 9'd6) && (pos_reg != POS_MAX) &&
                    (ins_reg == INS_WRITE) && write_ok_cur &&
                    (idx < {1'b0, tl_reg}) && (wr_addr < STORE_END);

    assign dlen    = ((kind_reg == RSP_RD_CC) || (kind_reg == RSP_RD_NDEF)) ?
                     {1'b0, tl_reg} : 9'd0;
    assign rd_addr = {1'b0, fo_reg} + {8'b0, rpos_reg} - 17'd1;

    assign ram_wr_en   = wr_hit;
    assign ram_rd_en   = is_pull && (kind_reg == RSP_RD_NDEF);
    assign ram_addr    = is_push ? wr_addr[AW-1:0] : rd_addr[AW-1:0];
    assign ram_wr_data = item.request_byte;

    assign len_wide = {{HW_W{1'b0}}, len_reg};

    // Frame fields, the decode of a finished frame and the response position on a pull.
    always_comb
    begin
        pcb_next  = pcb_reg;
        ins_next  = ins_reg;
        p1_next   = p1_reg;
        fo_next   = fo_reg;
        tl_next   = tl_reg;
        fid_next  = fid_reg;
        sel_next  = sel_reg;
        len_next  = len_reg;
        pos_next  = pos_reg;
        kind_next = kind_reg;
        rpos_next = rpos_reg;
        frame_len = {1'b0, pos_reg} + 10'd1;
        write_ok_new = 1'b0;

        if (is_push)
        begin
            unique case (pos_reg)
                9'd0:    pcb_next = item.request_byte;
                9'd2:    ins_next = item.request_byte;
                9'd3:    p1_next  = item.request_byte;
                9'd4:    fo_next  = {p1_reg, item.request_byte};
                9'd5:    tl_next  = item.request_byte;
                9'd6:    fid_next = {item.request_byte, 8'h00};
                9'd7:    fid_next = {fid_reg[15:8], item.request_byte};
                default: ;
            endcase

            if (wr_hit && (wr_addr_inc > 17'(len_reg)))
            begin
                len_next = LEN_W'(wr_addr_inc);
            end

            write_ok_new = (sel_reg == FILE_NDEF) &&
                           (({1'b0, fo_next} + {9'b0, tl_next}) <= STORE_END);

            if (item.request_last)
            begin
                pos_next = 9'd0;
                if (frame_len >= 10'd3)
                begin
                    unique case (ins_next)
                        INS_SELECT:
                        begin
                            if (frame_len >= 10'd4)
                            begin
                                if (p1_next == P1_BY_AID)
                                begin
                                    kind_next = RSP_OK;
                                    rpos_next = 9'd0;
                                end
                                else if ((p1_next == P1_BY_FILE) && (frame_len >= 10'd8))
                                begin
                                    rpos_next = 9'd0;
                                    if (fid_next == FID_CC)
                                    begin
                                        sel_next  = FILE_CC;
                                        kind_next = RSP_OK;
                                    end
                                    else if (fid_next == FID_NDEF)
                                    begin
                                        sel_next  = FILE_NDEF;
                                        kind_next = RSP_OK;
                                    end
                                    else
                                    begin
                                        kind_next = RSP_ERR;
                                    end
                                end
                            end
                        end
                        INS_READ:
                        begin
                            if (frame_len >= 10'd6)
                            begin
                                rpos_next = 9'd0;
                                if (sel_reg == FILE_CC)
                                begin
                                    kind_next = RSP_RD_CC;
                                end
                                else if (sel_reg == FILE_NDEF)
                                begin
                                    kind_next = RSP_RD_NDEF;
                                end
                                else
                                begin
                                    kind_next = RSP_ERR;
                                end
                            end
                        end
                        INS_WRITE:
                        begin
                            if (frame_len >= 10'd6)
                            begin
                                rpos_next = 9'd0;
                                kind_next = write_ok_new ? RSP_OK : RSP_ERR;
                            end
                        end
                        default:
                        begin
                            kind_next = RSP_OK;
                            rpos_next = 9'd0;
                        end
                    endcase
                end
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
        else if (is_pull && (kind_reg != RSP_NONE))
        begin
            if (rpos_reg >= (dlen + 9'd2))
            begin
                kind_next = RSP_NONE;
                rpos_next = 9'd0;
            end
            else
            begin
                rpos_next = rpos_reg + 9'd1;
            end
        end
    end

    // Response byte selection for the current pull.
    always_comb
    begin
        meta            = '0;
        meta.high_water = len_wide[HW_W-1:0];
        if (kind_reg != RSP_NONE)
        begin
            meta.resp_valid = 1'b1;
            meta.last       = (rpos_reg >= (dlen + 9'd2));
            if (rpos_reg == 9'd0)
            begin
                meta.direct_byte = pcb_reg;
            end
            else if (rpos_reg <= dlen)
            begin
                if (kind_reg == RSP_RD_CC)
                begin
                    if (rd_addr < 17'(CC_BYTES))
                    begin
                        meta.direct_byte = cc_byte(rd_addr[3:0]);
                    end
                end
                else if (rd_addr < STORE_END)
                begin
                    meta.use_mem = 1'b1;
                end
            end
            else if (rpos_reg == (dlen + 9'd1))
            begin
                meta.direct_byte = (kind_reg == RSP_ERR) ? SW1_ERR : SW1_OK;
            end
            else
            begin
                meta.direct_byte = (kind_reg == RSP_ERR) ? SW2_ERR : SW2_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pcb_reg  <= '0;
            ins_reg  <= '0;
            p1_reg   <= '0;
            fo_reg   <= '0;
            tl_reg   <= '0;
            fid_reg  <= '0;
            sel_reg  <= FILE_NONE;
            len_reg  <= '0;
            kind_reg <= RSP_NONE;
            rpos_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pcb_reg  <= pcb_next;
            ins_reg  <= ins_next;
            p1_reg   <= p1_next;
            fo_reg   <= fo_next;
            tl_reg   <= tl_next;
            fid_reg  <= fid_next;
            sel_reg  <= sel_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
            rpos_reg <= rpos_next;
        end
    end

    a_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg >= $past(len_reg))
        else $error("NDEF high-water mark went down");

    a_pos_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        is_push && item.request_last |=> pos_reg == 9'd0)
        else $error("byte position not cleared after end of frame");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> wr_addr < STORE_END && sel_reg == FILE_NDEF)
        else $error("store write outside the NDEF file");

endmodule

>>> hdl/type4_tag_apdu_responder.sv
// Top level of the Type 4 Tag APDU responder.
`timescale 1ns / 1ps

// Type 4 Tag APDU responder. Push request bytes (operation 0, CRC already
// stripped, request_last on the final byte) and pull response bytes
// (operation 1) over the req channel; every pull, and only a pull, yields one
// item on the rsp channel. A finished frame is decoded in the cycle its last
// byte is accepted: SELECT by AID or by file ID (E103 capability container,
// E104 NDEF), READ BINARY, WRITE BINARY into the NDEF store, and OK for
// anything else. Every response starts with the request's PCB. Rate: one
// request per clock, sustained while rsp is ready. The pull passes through a
// stage register that covers the registered read of the single-port NDEF
// store and then the output register; a stalled rsp holds both and drops
// req.ready once the stage is full. Write data goes into the store byte by
// byte as it arrives. The NDEF store has no reset: bytes never written read
// back undefined. The high-water mark is reported with each pulled byte.
module type4_tag_apdu_responder
    import tt4_pkg::*;
#(
    parameter int NDEF_STORE_BYTES = 8192
) (
    input  logic      clk,
    input  logic      rst_n,
    tt4_req_if.sink   req,
    tt4_rsp_if.source rsp
);

    localparam int AW = $clog2(NDEF_STORE_BYTES);

    req_item_t       item;
    rsp_meta_t       meta;
    logic            in_fire;
    logic            s1_move;
    logic            ram_wr_en;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wr_data;
    logic [7:0]      ram_rd_data;

    // Stage 1: pull metadata waiting for the store read data.
    logic            s1_valid_reg, s1_valid_next;
    rsp_meta_t       s1_meta_reg;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    logic            out_rv_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic [HW_W-1:0] out_hw_reg;

    assign item    = '{operation:    req.operation,
                       request_byte: req.request_byte,
                       request_last: req.request_last};
    assign in_fire = req.valid && req.ready;

    // Advance stage 1 whenever the output register is empty or being drained.
    assign s1_move   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_move;

    tt4_ctrl #(
        .NDEF_STORE_BYTES (NDEF_STORE_BYTES),
        .AW               (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .item        (item),
        .meta        (meta),
        .ram_wr_en   (ram_wr_en),
        .ram_rd_en   (ram_rd_en),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data)
    );

    tt4_ndef_ram #(
        .DEPTH (NDEF_STORE_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .rd_en   (ram_rd_en),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && (item.operation == OP_PULL))
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = s1_move ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture a pull's metadata, then merge store data.
    always_ff @(posedge clk)
    begin
        if (in_fire && (item.operation == OP_PULL))
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_rv_reg   <= s1_meta_reg.resp_valid;
            out_byte_reg <= s1_meta_reg.use_mem ? ram_rd_data : s1_meta_reg.direct_byte;
            out_last_reg <= s1_meta_reg.last;
            out_hw_reg   <= s1_meta_reg.high_water;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.response_valid  = out_rv_reg;
    assign rsp.response_byte   = out_byte_reg;
    assign rsp.response_last   = out_last_reg;
    assign rsp.ndef_high_water = out_hw_reg;

    a_pull_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && req.operation == OP_PULL |=> s1_valid_reg)
        else $error("accepted pull did not reach stage 1");

    a_last_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.response_last |-> rsp.response_valid)
        else $error("last flag on an empty response");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.response_valid |-> rsp.response_byte == 8'h00)
        else $error("nonzero byte on an empty response");

endmodule

>>> sim/type4_tag_apdu_responder_test.sv
// Self-checking testbench for the Type 4 Tag APDU responder.
`timescale 1ns / 1ps

import tt4_pkg::*;

// One pulled response byte as the block reports it.
typedef struct packed {
    logic            valid;
    logic [7:0]      data;
    logic            last;
    logic [HW_W-1:0] high_water;
} pulled_byte_t;

// Mirror of the tag: decodes pushed frames, predicts every pulled byte and
// checks the bytes that come back against the oldest prediction.
class tag_mirror;
    localparam int STORE_BYTES = 8192;

    logic [7:0]      cc_image [CC_BYTES];
    logic [7:0]      ndef_mem [STORE_BYTES];
    bit              ndef_written [STORE_BYTES];
    logic [HW_W-1:0] ndef_len = '0;
    file_sel_t       file_sel = FILE_NONE;
    logic [8:0]      frame_pos = '0;
    logic [7:0]      pcb = '0;
    logic [7:0]      ins = '0;
    logic [7:0]      p1 = '0;
    logic [15:0]     offset = '0;
    logic [7:0]      xfer_len = '0;
    logic [15:0]     fid = '0;
    rsp_kind_t       kind = RSP_NONE;
    logic [8:0]      rsp_pos = '0;
    pulled_byte_t    bytes_due [$];
    int unsigned     errors = 0;
    int unsigned     checked = 0;
    int unsigned     stored = 0;

    function new();
        cc_image = '{8'h00, 8'h0F, 8'h20, 8'h00, 8'hF6, 8'h00, 8'hF6, 8'h04,
                     8'h06, 8'hE1, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    endfunction

    function void queue_answer(rsp_kind_t k);
        kind = k;
        rsp_pos = '0;
    endfunction

    function bit write_allowed();
        return file_sel == FILE_NDEF && int'(offset) + int'(xfer_len) <= STORE_BYTES;
    endfunction

    function bit pending();
        return kind != RSP_NONE;
    endfunction

    // False when the next pull would return an NDEF byte never written.
    function bit pull_safe();
        int addr;
        if (kind != RSP_RD_NDEF || rsp_pos == 0 || int'(rsp_pos) > int'(xfer_len))
            return 1'b1;
        addr = int'(offset) + int'(rsp_pos) - 1;
        return addr >= STORE_BYTES || ndef_written[addr];
    endfunction

    function int outstanding();
        return bytes_due.size();
    endfunction

    function void note_request(logic op, logic [7:0] b, logic last);
        pulled_byte_t e;
        int p, len, dlen, addr, idx;
        if (op == OP_PULL) begin
            e = '0;
            e.high_water = ndef_len;
            if (kind != RSP_NONE) begin
                dlen = (kind == RSP_RD_CC || kind == RSP_RD_NDEF) ? int'(xfer_len) : 0;
                p = int'(rsp_pos);
                e.valid = 1'b1;
                if (p == 0)
                    e.data = pcb;
                else if (p <= dlen) begin
                    addr = int'(offset) + p - 1;
                    if (kind == RSP_RD_CC)
                        e.data = (addr < CC_BYTES) ? cc_image[addr] : 8'h00;
                    else
                        e.data = (addr < STORE_BYTES) ? ndef_mem[addr] : 8'h00;
                end
                else if (p == dlen + 1)
                    e.data = (kind == RSP_ERR) ? SW1_ERR : SW1_OK;
                else
                    e.data = (kind == RSP_ERR) ? SW2_ERR : SW2_OK;
                if (p + 1 >= dlen + 3) begin
                    e.last = 1'b1;
                    queue_answer(RSP_NONE);
                end
                else
                    rsp_pos = rsp_pos + 9'd1;
            end
            bytes_due.push_back(e);
            return;
        end

        p = int'(frame_pos);
        case (p)
            0: pcb = b;
            2: ins = b;
            3: p1 = b;
            4: offset = {p1, b};
            5: xfer_len = b;
            default: ;
        endcase
        if (p == 6)
            fid = {b, 8'h00};
        else if (p == 7)
            fid[7:0] = b;
        if (p >= 6 && p < int'(POS_MAX) && ins == INS_WRITE && write_allowed()) begin
            idx = p - 6;
            addr = int'(offset) + idx;
            if (idx < int'(xfer_len) && addr < STORE_BYTES) begin
                ndef_mem[addr] = b;
                ndef_written[addr] = 1'b1;
                stored++;
                if (addr + 1 > int'(ndef_len))
                    ndef_len = HW_W'(addr + 1);
            end
        end
        if (!last) begin
            if (p < int'(POS_MAX))
                frame_pos = frame_pos + 9'd1;
            return;
        end

        // Decode the finished frame; short frames leave everything as it was.
        frame_pos = '0;
        len = p + 1;
        if (len < 3)
            return;
        if (ins == INS_SELECT) begin
            if (len < 4)
                return;
            if (p1 == P1_BY_AID)
                queue_answer(RSP_OK);
            else if (p1 == P1_BY_FILE && len >= 8) begin
                if (fid == FID_CC) begin
                    file_sel = FILE_CC;
                    queue_answer(RSP_OK);
                end
                else if (fid == FID_NDEF) begin
                    file_sel = FILE_NDEF;
                    queue_answer(RSP_OK);
                end
                else
                    queue_answer(RSP_ERR);
            end
        end
        else if (ins == INS_READ) begin
            if (len >= 6)
                queue_answer(file_sel == FILE_CC ? RSP_RD_CC :
                             file_sel == FILE_NDEF ? RSP_RD_NDEF : RSP_ERR);
        end
        else if (ins == INS_WRITE) begin
            if (len >= 6)
                queue_answer(write_allowed() ? RSP_OK : RSP_ERR);
        end
        else
            queue_answer(RSP_OK);
    endfunction

    function void check_response(logic v, logic [7:0] b, logic l, logic [HW_W-1:0] hw);
        pulled_byte_t e;
        if (bytes_due.size() == 0) begin
            errors++;
            $display("%0t: response byte %h arrived with no pull waiting", $time, b);
            return;
        end
        e = bytes_due.pop_front();
        checked++;
        if (v !== e.valid) begin
            errors++;
            $display("%0t: response_valid expected %b actual %b", $time, e.valid, v);
        end
        if (b !== e.data) begin
            errors++;
            $display("%0t: response_byte expected %h actual %h", $time, e.data, b);
        end
        if (l !== e.last) begin
            errors++;
            $display("%0t: response_last expected %b actual %b", $time, e.last, l);
        end
        if (hw !== e.high_water) begin
            errors++;
            $display("%0t: ndef_high_water expected %0d actual %0d", $time,
                     e.high_water, hw);
        end
    endfunction
endclass

module type4_tag_apdu_responder_test;

    localparam int NDEF_BYTES   = 8192;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam logic [7:0] NDEF_AID [7] = '{8'hD2, 8'h76, 8'h00, 8'h00, 8'h85,
                                            8'h01, 8'h01};

    logic clk;
    logic rst_n;

    tt4_req_if req_ch ();
    tt4_rsp_if rsp_ch ();

    type4_tag_apdu_responder #(
        .NDEF_STORE_BYTES(NDEF_BYTES)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    tag_mirror   mirror;
    logic [7:0]  apdu [$];
    int unsigned requests_sent = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_left = 0;

    // 20 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive one request at the falling edge, optionally after idle cycles, and
    // hold it until the block takes it. Note it in the mirror at that edge so
    // the frame builders always see the state after every earlier request.
    task automatic put_request(logic op, logic [7:0] b, logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.operation    = op;
        req_ch.request_byte = b;
        req_ch.request_last = last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        mirror.note_request(op, b, last);
        requests_sent++;
    endtask

    // Pull carries junk in the byte and last fields; the block must ignore them.
    task automatic pull_one();
        put_request(OP_PULL, 8'($urandom), 1'($urandom));
    endtask

    // Drain the pending response, up to max_pulls bytes. Stop short of any
    // NDEF byte that was never written.
    task automatic pull_answer(int max_pulls);
        int n;
        n = 0;
        while (n < max_pulls && mirror.pending() && mirror.pull_safe())
        begin
            pull_one();
            n++;
        end
    endtask

    // Start a frame: PCB, CLA, INS, P1, P2, Lc/Le. PCB and CLA are mostly the
    // usual values, sometimes random, since the block only echoes the PCB.
    task automatic frame_head(logic [7:0] ins, logic [7:0] p1, logic [7:0] p2,
                              logic [7:0] lc);
        apdu.delete();
        apdu.push_back(($urandom_range(3) == 0) ? 8'($urandom) : {7'h01, 1'($urandom)});
        apdu.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
        apdu.push_back(ins);
        apdu.push_back(p1);
        apdu.push_back(p2);
        apdu.push_back(lc);
    endtask

    task automatic add_data(int n);
        repeat (n) apdu.push_back(8'($urandom));
    endtask

    task automatic trim_frame(int keep);
        while (apdu.size() > keep)
            apdu.pop_back();
    endtask

    // Push the frame in apdu, slipping in pulls between bytes now and then.
    task automatic send_apdu(int mid_pull_pct);
        for (int i = 0; i < apdu.size(); i++)
        begin
            if (i > 0 && $urandom_range(99) < mid_pull_pct && mirror.pull_safe())
                pull_one();
            put_request(OP_PUSH, apdu[i], i == apdu.size() - 1);
        end
    endtask

    task automatic select_file(logic [15:0] id);
        frame_head(INS_SELECT, P1_BY_FILE, 8'h0C, 8'h02);
        apdu.push_back(id[15:8]);
        apdu.push_back(id[7:0]);
    endtask

    task automatic select_aid();
        frame_head(INS_SELECT, P1_BY_AID, 8'h00, 8'h07);
        foreach (NDEF_AID[i])
            apdu.push_back(NDEF_AID[i]);
        apdu.push_back(8'h00);
    endtask

    task automatic read_binary(logic [15:0] off, logic [7:0] len);
        frame_head(INS_READ, off[15:8], off[7:0], len);
    endtask

    task automatic write_binary(logic [15:0] off, logic [7:0] len, int n);
        frame_head(INS_WRITE, off[15:8], off[7:0], len);
        add_data(n);
    endtask

    // Push a frame with no mid-frame pulls and take its whole answer.
    task automatic exchange();
        send_apdu(0);
        pull_answer(1000);
    endtask

    // Offsets mostly in the low area that random writes keep filling, some
    // near the end of the store, a few anywhere in the 16-bit space.
    function automatic logic [15:0] pick_offset();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 16'($urandom);
        if (r < 3)
            return 16'($urandom_range(NDEF_BYTES - 92, NDEF_BYTES - 1));
        return 16'($urandom_range(0, 240));
    endfunction

    // Receiver: stall at random, or hold off completely while hold_off_left
    // counts down.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_off_left--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every response byte taken at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            mirror.check_response(rsp_ch.response_valid, rsp_ch.response_byte,
                                  rsp_ch.response_last, rsp_ch.ndef_high_water);
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int idle_mix [4];
        int stall_mix [4];
        int phase_end;
        int pick;
        int len;
        int n;
        logic [15:0] off;

        idle_mix  = '{0, 47, 0, 14};
        stall_mix = '{0, 0, 47, 14};
        mirror = new();
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_PUSH;
        req_ch.request_byte = 8'h00;
        req_ch.request_last = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- Directed frames ----

        // Pull with nothing pending: valid low, all bytes zero.
        pull_one();

        // Frames of one and two bytes are dropped.
        frame_head(8'h00, 8'h00, 8'h00, 8'h00);
        trim_frame(1);
        exchange();
        frame_head(8'h00, 8'h00, 8'h00, 8'h00);
        trim_frame(2);
        exchange();

        // No file selected yet: READ and WRITE both answer 6A 82.
        read_binary(16'h0000, 8'h04);
        exchange();
        write_binary(16'h0000, 8'h02, 2);
        exchange();

        // SELECT by AID, then SELECT variants that must be dropped: only
        // three bytes, by file ID cut to seven bytes, and an unknown P1.
        select_aid();
        exchange();
        frame_head(INS_SELECT, P1_BY_AID, 8'h00, 8'h00);
        trim_frame(3);
        exchange();
        select_file(FID_CC);
        trim_frame(7);
        exchange();
        frame_head(INS_SELECT, 8'h02, 8'h00, 8'h02);
        add_data(2);
        exchange();

        // Unknown file ID answers 6A 82.
        select_file(16'hE105);
        exchange();

        // Capability container: whole, past its end, and at the top offset.
        select_file(FID_CC);
        exchange();
        read_binary(16'h0000, 8'(CC_BYTES));
        exchange();
        read_binary(16'h000A, 8'h0A);
        exchange();
        read_binary(16'hFFFF, 8'h02);
        exchange();

        // WRITE to the container is refused.
        write_binary(16'h0000, 8'h02, 2);
        exchange();

        // A new answering frame replaces a half-pulled response.
        read_binary(16'h0000, 8'h0A);
        send_apdu(0);
        pull_answer(3);
        select_aid();
        exchange();

        // A dropped frame leaves the pending response alone.
        read_binary(16'h0002, 8'h08);
        send_apdu(0);
        pull_answer(2);
        frame_head(8'h00, 8'h00, 8'h00, 8'h00);
        trim_frame(2);
        send_apdu(0);
        pull_answer(1000);

        // READ and WRITE of five bytes are dropped.
        read_binary(16'h0000, 8'h04);
        trim_frame(5);
        exchange();
        write_binary(16'h0000, 8'h04, 0);
        trim_frame(5);
        exchange();

        // NDEF file: fill the low area, then a write with missing data and
        // one with surplus data.
        select_file(FID_NDEF);
        exchange();
        write_binary(16'h0000, 8'd48, 48);
        exchange();
        write_binary(16'd60, 8'd16, 5);
        exchange();
        write_binary(16'd70, 8'd4, 9);
        exchange();
        read_binary(16'h0000, 8'd48);
        exchange();
        read_binary(16'd60, 8'd5);
        exchange();
        read_binary(16'd70, 8'd0);
        exchange();

        // Bounds: refuse a write that runs past the end, accept one that
        // ends on the last byte, read across the end, read far beyond it.
        write_binary(16'(NDEF_BYTES - 2), 8'd5, 5);
        exchange();
        write_binary(16'(NDEF_BYTES - 16), 8'd16, 16);
        exchange();
        read_binary(16'(NDEF_BYTES - 8), 8'd16);
        exchange();
        read_binary(16'hFF00, 8'd4);
        exchange();

        // Unknown instruction with the minimum three bytes answers OK.
        frame_head(8'h55, 8'h00, 8'h00, 8'h00);
        trim_frame(3);
        exchange();
        pull_one();

        // ---- Random frames over four idle/stall mixes ----
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    select_file(FID_NDEF);
                else if (pick < 15)
                    select_file(FID_CC);
                else if (pick < 18)
                    select_aid();
                else if (pick < 21)
                begin
                    frame_head(INS_SELECT, ($urandom_range(1) == 0) ? 8'($urandom) :
                               P1_BY_FILE, 8'h0C, 8'h02);
                    add_data(2);
                end
                else if (pick < 46)
                begin
                    off = pick_offset();
                    len = $urandom_range(0, 12);
                    n = ($urandom_range(4) == 0) ? $urandom_range(0, 16) : len;
                    write_binary(off, 8'(len), n);
                end
                else if (pick < 72)
                begin
                    off = pick_offset();
                    len = ($urandom_range(30) == 0) ? $urandom_range(0, 255) :
                                                       $urandom_range(0, 12);
                    read_binary(off, 8'(len));
                end
                else if (pick < 80)
                begin
                    frame_head(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                    add_data($urandom_range(0, 4));
                    trim_frame($urandom_range(3, 10));
                end
                else if (pick < 90)
                begin
                    // Noise: a short run of random bytes.
                    apdu.delete();
                    add_data($urandom_range(1, 9));
                end
                else
                begin
                    // Broken frame: a well-formed one cut off early.
                    case ($urandom_range(2))
                        0: select_file(($urandom_range(1) == 0) ? FID_NDEF : FID_CC);
                        1: read_binary(pick_offset(), 8'($urandom_range(0, 12)));
                        default: write_binary(pick_offset(), 8'd8, 8);
                    endcase
                    trim_frame($urandom_range(1, apdu.size() - 1));
                end
                send_apdu(10);
                if ($urandom_range(9) < 8)
                    pull_answer(1000);
                else
                    pull_answer($urandom_range(0, 3));
                if ($urandom_range(9) == 0 && mirror.pull_safe())
                    pull_one();
            end

            // After the first mix: long receiver hold-off while the sender
            // keeps pulling, so the block backs up and stalls its input.
            if (phase == 0)
            begin
                select_file(FID_CC);
                exchange();
                read_binary(16'h0000, 8'd12);
                send_apdu(0);
                hold_off_left = 150;
                pull_answer(1000);
            end
        end

        // Release the request channel and wait for the last answers.
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d checked response bytes; %0d NDEF bytes",
                 requests_sent, mirror.checked, mirror.stored);
        $display("stored, high water %0d, under four idle/stall mixes and one long hold-off.",
                 mirror.ndef_len);
        if (mirror.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hdl/tt4_pkg.sv
hdl/tt4_channels.sv
hdl/tt4_ndef_ram.sv
hdl/tt4_ctrl.sv
hdl/type4_tag_apdu_responder.sv
sim/type4_tag_apdu_responder_test.sv
